>>> sv/assert_macros.svh
// Assertion macros shared by the RTL files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, clocked on i_clk and disabled while reset is low.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on i_clk and disabled while reset is low.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> sv/tpi_pkg.sv
// Package with the breakpoint tables, fixed-point widths and shared types of the interpolator.
package tpi_pkg;

    localparam int IN_FRAC_BITS  = 8;
    localparam int OUT_FRAC_BITS = 16;
    localparam int SLOPE_FRAC    = 16;
    localparam int RE_POINTS     = 19;
    localparam int IM_POINTS     = 11;
    localparam longint VALUE_UNIT = 1000000;

    localparam int WL_W     = 20;
    localparam int RE_W     = 20;
    localparam int IM_W     = 18;
    localparam int STATUS_W = 2;

    // Breakpoints are in units of 10 pm, so the wavelength is scaled by 100.
    localparam int WL_SCALE = 100;

    localparam int X_W       = 27;
    // The widest segment of the imaginary table spans more than 2^22 scaled units.
    localparam int D_W       = 23;
    localparam int SLOPE_W   = 21;
    localparam int BASE_W    = 20;
    localparam int CORR_W    = 20;
    localparam int SUM_W     = 22;
    localparam int PROD_W    = SLOPE_W + D_W + 1;
    localparam int RND_SHIFT = IN_FRAC_BITS + SLOPE_FRAC;

    localparam longint RE_LAM [RE_POINTS] = '{
        150314, 155924, 163135, 171815, 180227, 187036, 193445, 197317, 202924,
        209199, 214405, 220545, 224816, 230957, 238431, 247374, 258585, 264990,
        269527 };
    localparam longint RE_VAL [RE_POINTS] = '{
        1551270, 1334140, 1032570, 658625, 284680, -53076, -354644, -559710,
        -837153, -1174910, -1452350, -1814230, -2079610, -2417370, -2887820,
        -3430640, -4130280, -4564540, -4878170 };
    localparam longint IM_LAM [IM_POINTS] = '{
        150090, 154500, 165593, 179759, 193657, 207554, 224656, 234410, 247368,
        256987, 270077 };
    localparam longint IM_VAL [IM_POINTS] = '{
        271084, 295181, 361446, 454819, 569277, 698795, 879518, 993976,
        1168670, 1304220, 1506020 };

    localparam logic signed [SUM_W-1:0] RE_SAT_HI =
        SUM_W'((longint'(1) << (RE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] RE_SAT_LO =
        SUM_W'(-(longint'(1) << (RE_W - 1)));
    localparam logic signed [SUM_W-1:0] IM_SAT_LO =
        SUM_W'(-(longint'(1) << (IM_W - 1)));
    localparam logic signed [SUM_W-1:0] IM_SAT_HI = '0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_RE_RANGE = 2'd1,
        ST_IM_RANGE = 2'd2
    } t_status;

    // Selected segment of one table: range flag, constants and offset into the segment.
    typedef struct packed {
        logic                      in_range;
        logic signed [BASE_W-1:0]  base;
        logic signed [SLOPE_W-1:0] slope;
        logic [D_W-1:0]            d;
    } t_seg;

endpackage

>>> sv/tpi_re_table.sv
// Segment lookup for the real permittivity table: range check, segment select and offset.
module tpi_re_table import tpi_pkg::*; (
    input  logic [X_W-1:0] i_x,
    output t_seg           o_seg
);

    localparam int NSEG = RE_POINTS - 1;
    localparam logic [X_W-1:0] X_FIRST = X_W'(RE_LAM[0] << IN_FRAC_BITS);
    localparam logic [X_W-1:0] X_LAST  = X_W'(RE_LAM[RE_POINTS-1] << IN_FRAC_BITS);

    logic [NSEG-1:0]           le;
    logic [NSEG-1:0]           sel;
    logic [X_W-1:0]            c_lo    [NSEG];
    logic signed [BASE_W-1:0]  c_base  [NSEG];
    logic signed [SLOPE_W-1:0] c_slope [NSEG];
    logic [X_W-1:0]            lo_sel;

    for (genvar k = 0; k < NSEG; k++) begin : g_seg
        localparam longint LO = RE_LAM[k] << IN_FRAC_BITS;
        localparam longint V0 = RE_VAL[k];
        localparam longint DV = RE_VAL[k+1] - RE_VAL[k];
        localparam longint DL = RE_LAM[k+1] - RE_LAM[k];
        localparam longint BN = V0 * (longint'(1) << OUT_FRAC_BITS);
        localparam longint BQ = ((BN < 0 ? -BN : BN) + VALUE_UNIT / 2) / VALUE_UNIT;
        localparam longint BV = BN < 0 ? -BQ : BQ;
        localparam longint SN = DV * (longint'(1) << (OUT_FRAC_BITS + SLOPE_FRAC));
        localparam longint SD = VALUE_UNIT * DL;
        localparam longint SQ = ((SN < 0 ? -SN : SN) + SD / 2) / SD;
        localparam longint SV = SN < 0 ? -SQ : SQ;

        assign c_lo[k]    = X_W'(LO);
        assign c_base[k]  = BASE_W'(BV);
        assign c_slope[k] = SLOPE_W'(SV);

        // The last segment takes everything above the inner breakpoints.
        if (k == NSEG - 1) begin : g_last
            assign le[k] = 1'b1;
        end else begin : g_mid
            localparam longint HI = RE_LAM[k+1] << IN_FRAC_BITS;
            assign le[k] = (i_x <= X_W'(HI));
        end
    end

    always_comb begin
        sel    = '0;
        lo_sel = '0;
        o_seg  = '0;
        for (int k = 0; k < NSEG; k++) begin
            if (k == 0) begin
                sel[k] = le[k];
            end else begin
                sel[k] = le[k] & ~le[k-1];
            end
        end
        for (int k = 0; k < NSEG; k++) begin
            if (sel[k]) begin
                lo_sel      = c_lo[k];
                o_seg.base  = c_base[k];
                o_seg.slope = c_slope[k];
            end
        end
        o_seg.in_range = (i_x >= X_FIRST) && (i_x <= X_LAST);
        o_seg.d        = D_W'(i_x - lo_sel);
    end

endmodule

>>> sv/tpi_im_table.sv
// Segment lookup for the imaginary permittivity table: range check, segment select and offset.
module tpi_im_table import tpi_pkg::*; (
    input  logic [X_W-1:0] i_x,
    output t_seg           o_seg
);

    localparam int NSEG = IM_POINTS - 1;
    localparam logic [X_W-1:0] X_FIRST = X_W'(IM_LAM[0] << IN_FRAC_BITS);
    localparam logic [X_W-1:0] X_LAST  = X_W'(IM_LAM[IM_POINTS-1] << IN_FRAC_BITS);

    logic [NSEG-1:0]           le;
    logic [NSEG-1:0]           sel;
    logic [X_W-1:0]            c_lo    [NSEG];
    logic signed [BASE_W-1:0]  c_base  [NSEG];
    logic signed [SLOPE_W-1:0] c_slope [NSEG];
    logic [X_W-1:0]            lo_sel;

    for (genvar k = 0; k < NSEG; k++) begin : g_seg
        localparam longint LO = IM_LAM[k] << IN_FRAC_BITS;
        localparam longint V0 = IM_VAL[k];
        localparam longint DV = IM_VAL[k+1] - IM_VAL[k];
        localparam longint DL = IM_LAM[k+1] - IM_LAM[k];
        localparam longint BN = V0 * (longint'(1) << OUT_FRAC_BITS);
        localparam longint BQ = ((BN < 0 ? -BN : BN) + VALUE_UNIT / 2) / VALUE_UNIT;
        localparam longint BV = BN < 0 ? -BQ : BQ;
        localparam longint SN = DV * (longint'(1) << (OUT_FRAC_BITS + SLOPE_FRAC));
        localparam longint SD = VALUE_UNIT * DL;
        localparam longint SQ = ((SN < 0 ? -SN : SN) + SD / 2) / SD;
        localparam longint SV = SN < 0 ? -SQ : SQ;

        assign c_lo[k]    = X_W'(LO);
        assign c_base[k]  = BASE_W'(BV);
        assign c_slope[k] = SLOPE_W'(SV);

        // The last segment takes everything above the inner breakpoints.
        if (k == NSEG - 1) begin : g_last
            assign le[k] = 1'b1;
        end else begin : g_mid
            localparam longint HI = IM_LAM[k+1] << IN_FRAC_BITS;
            assign le[k] = (i_x <= X_W'(HI));
        end
    end

    always_comb begin
        sel    = '0;
        lo_sel = '0;
        o_seg  = '0;
        for (int k = 0; k < NSEG; k++) begin
            if (k == 0) begin
                sel[k] = le[k];
            end else begin
                sel[k] = le[k] & ~le[k-1];
            end
        end
        for (int k = 0; k < NSEG; k++) begin
            if (sel[k]) begin
                lo_sel      = c_lo[k];
                o_seg.base  = c_base[k];
                o_seg.slope = c_slope[k];
            end
        end
        o_seg.in_range = (i_x >= X_FIRST) && (i_x <= X_LAST);
        o_seg.d        = D_W'(i_x - lo_sel);
    end

endmodule

>>> sv/tpi_lerp.sv
// Linear interpolation within one segment: slope times offset, rounded, plus the segment base.
module tpi_lerp import tpi_pkg::*; (
    input  t_seg                     i_seg,
    output logic signed [SUM_W-1:0]  o_value
);

    localparam logic signed [PROD_W-1:0] RND_POS = PROD_W'(longint'(1) << (RND_SHIFT - 1));
    localparam logic signed [PROD_W-1:0] RND_NEG = PROD_W'((longint'(1) << (RND_SHIFT - 1)) - 1);

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [CORR_W-1:0] corr;

    // The offset is never negative, so it enters the multiplier with a zero sign bit.
    assign prod = $signed(i_seg.slope) * $signed({1'b0, i_seg.d});

    // Round half away from zero before the arithmetic shift.
    assign prod_rnd = prod + (prod[PROD_W-1] ? RND_NEG : RND_POS);
    assign corr     = $signed(prod_rnd[RND_SHIFT +: CORR_W]);
    assign o_value  = SUM_W'(corr) + SUM_W'($signed(i_seg.base));

endmodule

>>> sv/tabulated_permittivity_interpolator_top.sv
// Top level of the tabulated permittivity interpolator: input register, two tables, result register.
//
//  channel  | handshake         | words
//  ---------+-------------------+-------------------------------------------------------
//  input    | start, busy       | i_wavelength
//  result   | o_valid (strobe)  | o_re_permittivity, o_im_permittivity, o_status
//
// A word is taken at every edge with start high; busy stays low, so one word per cycle.
// Each result passes the input register and then the result register, and is on the outputs
// for one cycle, marked by o_valid.
// The latency is set by the input register and the result register; the table lookup,
// the multiply per part and the saturation sit between them.
// Synchronous active-low reset clears the valid flags only.
// The receiver cannot stall, so results are never held back.
`include "assert_macros.svh"

module tabulated_permittivity_interpolator_top import tpi_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [WL_W-1:0]         i_wavelength,
    output logic                    o_valid,
    output logic signed [RE_W-1:0]  o_re_permittivity,
    output logic signed [IM_W-1:0]  o_im_permittivity,
    output logic [STATUS_W-1:0]     o_status
);

    logic                    r_in_vld;
    logic                    n_in_vld;
    logic [WL_W-1:0]         r_wl;
    logic [WL_W-1:0]         n_wl;
    logic                    r_out_vld;
    logic signed [RE_W-1:0]  r_re;
    logic signed [RE_W-1:0]  n_re;
    logic signed [IM_W-1:0]  r_im;
    logic signed [IM_W-1:0]  n_im;
    t_status                 r_status;
    t_status                 n_status;

    logic [X_W-1:0]          x;
    t_seg                    re_seg;
    t_seg                    im_seg;
    logic signed [SUM_W-1:0] re_sum;
    logic signed [SUM_W-1:0] im_sum;
    logic signed [SUM_W-1:0] im_neg;
    logic signed [SUM_W-1:0] re_sat;
    logic signed [SUM_W-1:0] im_sat;

    assign busy     = 1'b0;
    assign n_in_vld = start && !busy;
    assign n_wl     = (start && !busy) ? i_wavelength : r_wl;

    assign x = X_W'(r_wl) * X_W'(WL_SCALE);

    tpi_re_table u_re_table (
        .i_x   (x),
        .o_seg (re_seg)
    );

    tpi_im_table u_im_table (
        .i_x   (x),
        .o_seg (im_seg)
    );

    tpi_lerp u_re_lerp (
        .i_seg   (re_seg),
        .o_value (re_sum)
    );

    tpi_lerp u_im_lerp (
        .i_seg   (im_seg),
        .o_value (im_sum)
    );

    always_comb begin
        im_neg = -im_sum;

        if (re_sum > RE_SAT_HI) begin
            re_sat = RE_SAT_HI;
        end else if (re_sum < RE_SAT_LO) begin
            re_sat = RE_SAT_LO;
        end else begin
            re_sat = re_sum;
        end

        if (im_neg > IM_SAT_HI) begin
            im_sat = IM_SAT_HI;
        end else if (im_neg < IM_SAT_LO) begin
            im_sat = IM_SAT_LO;
        end else begin
            im_sat = im_neg;
        end

        // The real range is checked first; either miss zeroes both parts.
        if (!re_seg.in_range) begin
            n_status = ST_RE_RANGE;
            n_re     = '0;
            n_im     = '0;
        end else if (!im_seg.in_range) begin
            n_status = ST_IM_RANGE;
            n_re     = '0;
            n_im     = '0;
        end else begin
            n_status = ST_OK;
            n_re     = RE_W'(re_sat);
            n_im     = IM_W'(im_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wl <= n_wl;
        if (r_in_vld) begin
            r_re     <= n_re;
            r_im     <= n_im;
            r_status <= n_status;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_re_permittivity = r_re;
    assign o_im_permittivity = r_im;
    assign o_status          = r_status;

    `ASSERT_NXT(a_word_gives_result, r_in_vld, o_valid)
    `ASSERT_IMP(a_result_has_word, o_valid, $past(r_in_vld))
    `ASSERT_IMP(a_miss_zeroes, o_valid && (o_status != ST_OK), (o_re_permittivity == '0) && (o_im_permittivity == '0))
    `ASSERT_IMP(a_im_not_positive, o_valid, o_im_permittivity <= 0)

endmodule
